### hw/rtl/asrc_pkg.sv
// Shared types and constants for the adaptive send rate controller.
package asrc_pkg;

	// Configuration register indexes
	localparam logic [2:0] REG_INTERVAL0  = 3'd0;
	localparam logic [2:0] REG_INTERVAL1  = 3'd1;
	localparam logic [2:0] REG_INTERVAL2  = 3'd2;
	localparam logic [2:0] REG_INTERVAL3  = 3'd3;
	localparam logic [2:0] REG_STABLE     = 3'd4;
	localparam logic [2:0] REG_HOLD       = 3'd5;
	localparam logic [2:0] REG_HEAP_FLOOR = 3'd6;

	// Register reset values
	localparam logic [15:0] RST_INTERVAL0  = 16'd500;
	localparam logic [15:0] RST_INTERVAL1  = 16'd1000;
	localparam logic [15:0] RST_INTERVAL2  = 16'd2000;
	localparam logic [15:0] RST_INTERVAL3  = 16'd4000;
	localparam logic [7:0]  RST_STABLE     = 8'd24;
	localparam logic [15:0] RST_HOLD       = 16'd15000;
	localparam logic [23:0] RST_HEAP_FLOOR = 24'd12288;

	localparam logic [1:0] MAX_LEVEL = 2'd3;

	typedef enum logic [2:0] {
		CAUSE_NONE      = 3'd0,
		CAUSE_FAIL      = 3'd1,
		CAUSE_OVERWRITE = 3'd2,
		CAUSE_HEAP      = 3'd3,
		CAUSE_SLOW      = 3'd4,
		CAUSE_STABLE    = 3'd5
	} cause_t;

	typedef struct packed {
		logic [3:0][15:0] interval;
		logic [7:0]       stable_needed;
		logic [15:0]      hold_ms;
		logic [23:0]      heap_floor;
	} cfg_t;

	typedef struct packed {
		logic        send_ok;
		logic [15:0] send_time_ms;
		logic [31:0] overwrite_count;
		logic [23:0] free_heap_bytes;
		logic [31:0] now_ms;
	} item_t;

	typedef struct packed {
		logic [15:0] avg_send_ms;
		logic [1:0]  level;
		logic [7:0]  good_count;
		logic [31:0] last_change;
		logic [31:0] seen_overwrite;
	} state_t;

	typedef struct packed {
		logic [1:0]  new_level;
		logic [15:0] interval_ms;
		cause_t      cause;
		logic        level_changed;
	} result_t;

endpackage

### hw/rtl/asrc_step.sv
// Combinational update of controller state and result for one send report.
module asrc_step (
	input  asrc_pkg::cfg_t    cfg,
	input  asrc_pkg::state_t  st,
	input  asrc_pkg::item_t   item,
	output asrc_pkg::state_t  st_next,
	output asrc_pkg::result_t res
);
	import asrc_pkg::*;

	logic [18:0] avg_sum;
	logic [15:0] avg_new;
	logic [15:0] interval;
	logic        overwritten;
	logic        heap_short;
	logic        slow;
	logic        big_step;
	logic        congest;
	logic        fast;
	logic [7:0]  cnt_inc;
	logic [31:0] elapsed;
	logic        step_down;
	logic [2:0]  level_sum;
	logic [1:0]  level_new;
	cause_t      cause;

	// Smoothed send time: first sample as is, then 7/8 old + 1/8 new
	assign avg_sum = 19'(st.avg_send_ms) * 19'd7 + 19'(item.send_time_ms);
	assign avg_new = (st.avg_send_ms == 16'd0) ? item.send_time_ms : avg_sum[18:3];

	// Congestion checks against the interval of the current level
	assign interval    = cfg.interval[st.level];
	assign overwritten = item.overwrite_count != st.seen_overwrite;
	assign heap_short  = item.free_heap_bytes < cfg.heap_floor;
	assign slow        = (20'(item.send_time_ms) * 20'd10) >= (20'(interval) * 20'd7);
	assign big_step    = 17'(item.send_time_ms) >= {interval, 1'b0};
	assign congest     = !item.send_ok || overwritten || heap_short || slow;

	// Step-down checks
	assign fast      = {avg_new, 2'b00} < 18'(interval);
	assign cnt_inc   = st.good_count + 8'd1;
	assign elapsed   = item.now_ms - st.last_change;
	assign step_down = (st.level != 2'd0) && fast && (cnt_inc >= cfg.stable_needed)
		&& (elapsed >= 32'(cfg.hold_ms));

	assign level_sum = 3'(st.level) + ((!item.send_ok || big_step) ? 3'd2 : 3'd1);

	// Next state and cause
	always_comb begin
		st_next                = st;
		st_next.avg_send_ms    = avg_new;
		st_next.seen_overwrite = item.overwrite_count;
		level_new              = st.level;
		cause                  = CAUSE_NONE;
		if (congest) begin
			level_new           = (level_sum > 3'(MAX_LEVEL)) ? MAX_LEVEL : level_sum[1:0];
			st_next.good_count  = 8'd0;
			st_next.last_change = item.now_ms;
			if (!item.send_ok) begin
				cause = CAUSE_FAIL;
			end else if (overwritten) begin
				cause = CAUSE_OVERWRITE;
			end else if (heap_short) begin
				cause = CAUSE_HEAP;
			end else begin
				cause = CAUSE_SLOW;
			end
		end else if (step_down) begin
			level_new           = st.level - 2'd1;
			cause               = CAUSE_STABLE;
			st_next.good_count  = 8'd0;
			st_next.last_change = item.now_ms;
		end else if (!fast) begin
			st_next.good_count = 8'd0;
		end else if (st.level != 2'd0) begin
			st_next.good_count = cnt_inc;
		end
		st_next.level = level_new;
	end

	assign res.new_level     = level_new;
	assign res.interval_ms   = cfg.interval[level_new];
	assign res.cause         = cause;
	assign res.level_changed = level_new != st.level;

endmodule

### hw/rtl/adaptive_send_rate_controller.sv
// Top level of the adaptive send rate controller.
// Takes one send report per clock while in_stall is low and returns one result per
// report. A report is captured in the input register; once the output register is
// free, the rate decision is made from it and the controller state, the state is
// updated and the result is loaded into the output register, so a following report
// sees the updated state with no gap.
// When the output register is full and stalled, the input register still takes
// one more report and then in_stall rises until the output moves. Configuration
// writes take effect on the next clock and are expected only while no report is
// in flight.
module adaptive_send_rate_controller (
	input  logic        clk,
	input  logic        arst_n,
	// configuration
	input  logic        cfg_we,
	input  logic [2:0]  cfg_index,
	input  logic [23:0] cfg_data,
	// send reports
	input  logic        in_valid,
	output logic        in_stall,
	input  logic        send_ok,
	input  logic [15:0] send_time_ms,
	input  logic [31:0] overwrite_count,
	input  logic [23:0] free_heap_bytes,
	input  logic [31:0] now_ms,
	// results
	output logic        out_valid,
	input  logic        out_stall,
	output logic [1:0]  new_level,
	output logic [15:0] interval_ms,
	output logic [2:0]  cause,
	output logic        level_changed
);
	import asrc_pkg::*;

	cfg_t    cfg_q;
	state_t  state_q;
	state_t  state_next;
	item_t   item_s1;
	logic    valid_s1;
	result_t res;
	result_t res_s2;
	logic    valid_s2;
	logic    out_free;
	logic    advance;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.interval[0] <= RST_INTERVAL0;
			cfg_q.interval[1] <= RST_INTERVAL1;
			cfg_q.interval[2] <= RST_INTERVAL2;
			cfg_q.interval[3] <= RST_INTERVAL3;
			cfg_q.stable_needed <= RST_STABLE;
			cfg_q.hold_ms <= RST_HOLD;
			cfg_q.heap_floor <= RST_HEAP_FLOOR;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_INTERVAL0:  cfg_q.interval[0] <= cfg_data[15:0];
				REG_INTERVAL1:  cfg_q.interval[1] <= cfg_data[15:0];
				REG_INTERVAL2:  cfg_q.interval[2] <= cfg_data[15:0];
				REG_INTERVAL3:  cfg_q.interval[3] <= cfg_data[15:0];
				REG_STABLE:     cfg_q.stable_needed <= cfg_data[7:0];
				REG_HOLD:       cfg_q.hold_ms <= cfg_data[15:0];
				REG_HEAP_FLOOR: cfg_q.heap_floor <= cfg_data;
				default: ;
			endcase
		end
	end

	// Pipeline flow control
	assign out_free = !valid_s2 || !out_stall;
	assign advance  = valid_s1 && out_free;
	assign in_stall = valid_s1 && !out_free;

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			item_s1 <= '{send_ok, send_time_ms, overwrite_count, free_heap_bytes, now_ms};
		end
	end

	asrc_step u_step (
		.cfg     (cfg_q),
		.st      (state_q),
		.item    (item_s1),
		.st_next (state_next),
		.res     (res)
	);

	// Controller state, updated as a report leaves the input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= '0;
		end else if (advance) begin
			state_q <= state_next;
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (out_free) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_s2 <= res;
		end
	end

	assign out_valid     = valid_s2;
	assign new_level     = res_s2.new_level;
	assign interval_ms   = res_s2.interval_ms;
	assign cause         = res_s2.cause;
	assign level_changed = res_s2.level_changed;

	// A level change always carries a reason
	a_change_has_cause: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && level_changed |-> cause != CAUSE_NONE)
		else $error("level changed with no cause");

	// A stable step-down always lowers the level
	a_stable_changes: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && cause == CAUSE_STABLE |-> level_changed)
		else $error("stable cause without level change");

	// State moves only when a transaction passes to the output
	a_state_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!advance |=> $stable(state_q))
		else $error("state changed without a transaction");

	// Input stalls only when both the input and output registers hold a report
	a_stall_full: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> valid_s1 && valid_s2)
		else $error("input stalled with room in the pipeline");

endmodule

### tb/asrc_rate_checker.sv
// Channel monitor for the adaptive send rate controller: predicts each result and compares it.
`timescale 1ns / 1ps

module asrc_rate_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [2:0]  cfg_index,
	input  logic [23:0] cfg_data,
	input  logic        in_valid,
	input  logic        in_stall,
	input  logic        send_ok,
	input  logic [15:0] send_time_ms,
	input  logic [31:0] overwrite_count,
	input  logic [23:0] free_heap_bytes,
	input  logic [31:0] now_ms,
	input  logic        out_valid,
	input  logic        out_stall,
	input  logic [1:0]  new_level,
	input  logic [15:0] interval_ms,
	input  logic [2:0]  cause,
	input  logic        level_changed,
	output int          fail_count,
	output int          pending
);
	import asrc_pkg::*;

	// Shadow of the configuration registers
	logic [15:0] iv [4];
	logic [7:0]  stable_need;
	logic [15:0] hold_ms;
	logic [23:0] heap_floor;

	// Shadow of the controller state
	logic [15:0] avg_ms;
	logic [1:0]  level_q;
	logic [7:0]  good_cnt;
	logic [31:0] change_ms;
	logic [31:0] ow_seen;

	result_t predicted_rates [$];
	int      result_idx;

	// Rate decision for one send report; advances the shadow state
	function automatic result_t next_rate(input item_t it);
		logic [31:0] send32;
		logic [31:0] iv32;
		logic [31:0] avg32;
		logic [1:0]  old_lvl;
		logic [1:0]  lvl;
		logic [2:0]  sum;
		logic        ow_chg;
		logic        heap_lo;
		logic        stepped;
		cause_t      why;
		result_t     r;
		old_lvl = level_q;
		lvl = old_lvl;
		iv32 = {16'b0, iv[old_lvl]};
		send32 = {16'b0, it.send_time_ms};
		why = CAUSE_NONE;

		// first sample taken as is, then 7/8 old + 1/8 new
		avg32 = (avg_ms == 16'd0) ? send32 : (({16'b0, avg_ms} * 32'd7 + send32) / 32'd8);
		avg_ms = avg32[15:0];

		ow_chg = it.overwrite_count != ow_seen;
		ow_seen = it.overwrite_count;
		heap_lo = it.free_heap_bytes < heap_floor;

		if (!it.send_ok || ow_chg || heap_lo || send32 * 32'd10 >= iv32 * 32'd7) begin
			// congestion: step up by one or two, clamp at the top level
			sum = {1'b0, old_lvl} + ((!it.send_ok || send32 >= iv32 * 32'd2) ? 3'd2 : 3'd1);
			lvl = (sum > {1'b0, MAX_LEVEL}) ? MAX_LEVEL : sum[1:0];
			why = !it.send_ok ? CAUSE_FAIL : ow_chg ? CAUSE_OVERWRITE :
				heap_lo ? CAUSE_HEAP : CAUSE_SLOW;
			good_cnt = 8'd0;
			change_ms = it.now_ms;
		end else begin
			// calm send: count toward a step down
			stepped = 1'b0;
			if (old_lvl != 2'd0 && {16'b0, avg_ms} * 32'd4 < iv32) begin
				good_cnt = good_cnt + 8'd1;
				if (good_cnt >= stable_need &&
					(it.now_ms - change_ms) >= {16'b0, hold_ms}) begin
					lvl = old_lvl - 2'd1;
					why = CAUSE_STABLE;
					good_cnt = 8'd0;
					change_ms = it.now_ms;
					stepped = 1'b1;
				end
			end
			if (!stepped && {16'b0, avg_ms} * 32'd4 >= iv32)
				good_cnt = 8'd0;
		end

		level_q = lvl;
		r.new_level = lvl;
		r.interval_ms = iv[lvl];
		r.cause = why;
		r.level_changed = lvl != old_lvl;
		return r;
	endfunction

	// Watch config writes and both channels at the rising edge
	always @(posedge clk or negedge arst_n) begin
		item_t   it;
		result_t want;
		if (!arst_n) begin
			iv[0] = RST_INTERVAL0;
			iv[1] = RST_INTERVAL1;
			iv[2] = RST_INTERVAL2;
			iv[3] = RST_INTERVAL3;
			stable_need = RST_STABLE;
			hold_ms = RST_HOLD;
			heap_floor = RST_HEAP_FLOOR;
			avg_ms = '0;
			level_q = '0;
			good_cnt = '0;
			change_ms = '0;
			ow_seen = '0;
			predicted_rates.delete();
			pending = 0;
			fail_count = 0;
			result_idx = 0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					REG_INTERVAL0:  iv[0] = cfg_data[15:0];
					REG_INTERVAL1:  iv[1] = cfg_data[15:0];
					REG_INTERVAL2:  iv[2] = cfg_data[15:0];
					REG_INTERVAL3:  iv[3] = cfg_data[15:0];
					REG_STABLE:     stable_need = cfg_data[7:0];
					REG_HOLD:       hold_ms = cfg_data[15:0];
					REG_HEAP_FLOOR: heap_floor = cfg_data;
					default: ;
				endcase
			end

			// result transaction
			if (out_valid && !out_stall) begin
				if (predicted_rates.size() == 0) begin
					if (fail_count < 10)
						$display("result %0d arrived with no report pending", result_idx);
					fail_count++;
				end else begin
					want = predicted_rates.pop_front();
					if (new_level !== want.new_level || interval_ms !== want.interval_ms ||
						cause !== want.cause || level_changed !== want.level_changed) begin
						if (fail_count < 10)
							$display({"result %0d: want lvl %0d iv %0d cause %0d chg %0b,",
								" got lvl %0d iv %0d cause %0d chg %0b"},
								result_idx, want.new_level, want.interval_ms, want.cause,
								want.level_changed, new_level, interval_ms, cause,
								level_changed);
						fail_count++;
					end
				end
				result_idx++;
			end

			// report transaction
			if (in_valid && !in_stall) begin
				it.send_ok = send_ok;
				it.send_time_ms = send_time_ms;
				it.overwrite_count = overwrite_count;
				it.free_heap_bytes = free_heap_bytes;
				it.now_ms = now_ms;
				predicted_rates.push_back(next_rate(it));
			end
			pending = predicted_rates.size();
		end
	end

endmodule

### tb/adaptive_send_rate_controller_tb.sv
// Stimulus and verdict for the adaptive send rate controller.
`timescale 1ns / 1ps

module adaptive_send_rate_controller_tb;
	import asrc_pkg::*;

	localparam int         CYCLE_LIMIT = 200000;
	localparam logic [2:0] REG_UNUSED  = 3'd7;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_we = 1'b0;
	logic [2:0]  cfg_index = '0;
	logic [23:0] cfg_data = '0;
	logic        in_valid = 1'b0;
	logic        in_stall;
	logic        send_ok = 1'b0;
	logic [15:0] send_time_ms = '0;
	logic [31:0] overwrite_count = '0;
	logic [23:0] free_heap_bytes = '0;
	logic [31:0] now_ms = '0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic [1:0]  new_level;
	logic [15:0] interval_ms;
	logic [2:0]  cause;
	logic        level_changed;

	int fail_count;
	int pending;
	int cycle_count;

	// stimulus context
	bit          quiet = 1'b0;
	cfg_t        cur_cfg;
	logic [31:0] cur_now;
	logic [31:0] cur_ow;

	adaptive_send_rate_controller dut (
		.clk(clk), .arst_n(arst_n),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.in_valid(in_valid), .in_stall(in_stall),
		.send_ok(send_ok), .send_time_ms(send_time_ms), .overwrite_count(overwrite_count),
		.free_heap_bytes(free_heap_bytes), .now_ms(now_ms),
		.out_valid(out_valid), .out_stall(out_stall),
		.new_level(new_level), .interval_ms(interval_ms), .cause(cause),
		.level_changed(level_changed)
	);

	asrc_rate_checker rate_chk (
		.clk(clk), .arst_n(arst_n),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.in_valid(in_valid), .in_stall(in_stall),
		.send_ok(send_ok), .send_time_ms(send_time_ms), .overwrite_count(overwrite_count),
		.free_heap_bytes(free_heap_bytes), .now_ms(now_ms),
		.out_valid(out_valid), .out_stall(out_stall),
		.new_level(new_level), .interval_ms(interval_ms), .cause(cause),
		.level_changed(level_changed),
		.fail_count(fail_count), .pending(pending)
	);

	always #5 clk = ~clk;

	// receiver backpressure
	always @(negedge clk)
		out_stall <= (arst_n && !quiet) ? ($urandom_range(0, 99) < 8) : 1'b0;

	// run limit
	initial begin
		cycle_count = 0;
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("adaptive_send_rate_controller test failed");
		$finish;
	end

	// one register write; leaves cfg_we high for a following write
	task automatic write_one(input logic [2:0] idx, input logic [23:0] data);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(negedge clk);
	endtask

	task automatic write_regs(input cfg_t c, input bit poke_unused);
		write_one(REG_INTERVAL0, {8'b0, c.interval[0]});
		write_one(REG_INTERVAL1, {8'b0, c.interval[1]});
		write_one(REG_INTERVAL2, {8'b0, c.interval[2]});
		write_one(REG_INTERVAL3, {8'b0, c.interval[3]});
		write_one(REG_STABLE, {16'b0, c.stable_needed});
		write_one(REG_HOLD, {8'b0, c.hold_ms});
		write_one(REG_HEAP_FLOOR, c.heap_floor);
		if (poke_unused)
			write_one(REG_UNUSED, 24'($urandom));
		cfg_we <= 1'b0;
		cur_cfg = c;
	endtask

	// called and returns at a falling edge
	task automatic send_item(input logic ok, input logic [15:0] snd, input logic [31:0] ow,
		input logic [23:0] heap, input logic [31:0] now);
		while (!quiet && $urandom_range(0, 99) < 8) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		send_ok <= ok;
		send_time_ms <= snd;
		overwrite_count <= ow;
		free_heap_bytes <= heap;
		now_ms <= now;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		@(negedge clk);
	endtask

	// mostly calm sends, with congestion events and raw noise mixed in
	task automatic rand_item(input int cong_pct, input int noise_pct, input int adv_max);
		int          r;
		logic [15:0] min_iv;
		logic        ok;
		logic [15:0] snd;
		logic [31:0] ow;
		logic [23:0] heap;
		min_iv = cur_cfg.interval[0];
		for (int i = 1; i < 4; i++)
			if (cur_cfg.interval[i] < min_iv) min_iv = cur_cfg.interval[i];
		r = $urandom_range(0, 99);
		cur_now = cur_now + $urandom_range(0, adv_max);
		if (r < noise_pct) begin
			ok = 1'($urandom);
			snd = 16'($urandom);
			ow = $urandom;
			heap = 24'($urandom);
			cur_ow = ow;
			send_item(ok, snd, ow, heap, $urandom);
		end else begin
			ok = 1'b1;
			ow = cur_ow;
			heap = 24'($urandom_range(cur_cfg.heap_floor, 24'hFFFFFF));
			snd = ($urandom_range(0, 99) < 85) ? 16'($urandom_range(0, min_iv / 5)) :
				16'($urandom_range(0, min_iv / 2));
			if (r < noise_pct + cong_pct) begin
				case ($urandom_range(0, 3))
					0: ok = 1'b0;
					1: begin
						ow = cur_ow + $urandom_range(1, 4);
						cur_ow = ow;
					end
					2: heap = (cur_cfg.heap_floor != 0) ?
						24'($urandom_range(0, cur_cfg.heap_floor - 1)) : heap;
					default: snd = 16'($urandom_range(0, 65535));
				endcase
			end
			send_item(ok, snd, ow, heap, cur_now);
		end
	endtask

	// wait for every result, then let the pipeline settle
	task automatic drain;
		in_valid <= 1'b0;
		while (pending != 0) @(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	task automatic run_phase(input int n, input int cong_pct, input int noise_pct,
		input int adv_max);
		// open with a failed send so the level starts high
		cur_now = cur_now + 1;
		send_item(1'b0, 16'd0, cur_ow, 24'hFFFFFF, cur_now);
		for (int i = 1; i < n; i++)
			rand_item(cong_pct, noise_pct, adv_max);
		drain();
	endtask

	initial begin
		cfg_t c;
		cur_cfg.interval[0] = RST_INTERVAL0;
		cur_cfg.interval[1] = RST_INTERVAL1;
		cur_cfg.interval[2] = RST_INTERVAL2;
		cur_cfg.interval[3] = RST_INTERVAL3;
		cur_cfg.stable_needed = RST_STABLE;
		cur_cfg.hold_ms = RST_HOLD;
		cur_cfg.heap_floor = RST_HEAP_FLOOR;

		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// directed, reset settings
		send_item(1'b1, 16'd100, 32'd0, 24'hFFFFFF, 32'd1000);        // first sample
		send_item(1'b1, 16'd0, 32'd0, 24'd20000, 32'd2000);
		send_item(1'b1, 16'd349, 32'd0, 24'd20000, 32'd3000);         // just under slow
		send_item(1'b1, 16'd350, 32'd0, 24'd20000, 32'd4000);         // slow, step of one
		send_item(1'b1, 16'hFFFF, 32'd0, 24'd20000, 32'd5000);        // very slow, step of two
		send_item(1'b0, 16'd0, 32'd0, 24'd20000, 32'd6000);           // fail at top level
		send_item(1'b1, 16'd10, 32'hFFFFFFFF, 24'd20000, 32'd7000);   // overwrite
		send_item(1'b1, 16'd10, 32'hFFFFFFFF, 24'd0, 32'd8000);       // heap empty
		send_item(1'b1, 16'd10, 32'hFFFFFFFF, 24'd12287, 32'd9000);   // heap just low
		send_item(1'b1, 16'd10, 32'hFFFFFFFF, 24'd12288, 32'hFFFFFFFF);
		send_item(1'b1, 16'd0, 32'hFFFFFFFF, 24'hFFFFFF, 32'd0);      // time wraps
		send_item(1'b1, 16'hFFFF, 32'd0, 24'hFFFFFF, 32'd100);        // overwrite beats slow
		send_item(1'b0, 16'hFFFF, 32'd5, 24'd0, 32'd200);             // fail beats all
		send_item(1'b1, 16'd0, 32'd5, 24'd0, 32'd300);
		send_item(1'b1, 16'd0, 32'd5, 24'd30000, 32'd400);
		cur_ow = 32'd5;
		cur_now = 32'd400;
		drain();

		// short intervals, quick step down
		c.interval[0] = 16'd100;
		c.interval[1] = 16'd200;
		c.interval[2] = 16'd400;
		c.interval[3] = 16'd800;
		c.stable_needed = 8'd3;
		c.hold_ms = 16'd500;
		c.heap_floor = 24'd1000;
		write_regs(c, 1'b1);
		run_phase(220, 10, 4, 300);

		// lowest settings
		for (int i = 0; i < 4; i++) c.interval[i] = 16'd1;
		c.stable_needed = 8'd1;
		c.hold_ms = 16'd0;
		c.heap_floor = 24'd0;
		write_regs(c, 1'b0);
		run_phase(200, 6, 4, 10);

		// highest settings; long calm run lets the good count wrap
		for (int i = 0; i < 4; i++) c.interval[i] = 16'hFFFF;
		c.stable_needed = 8'hFF;
		c.hold_ms = 16'hFFFF;
		c.heap_floor = 24'hFFFFFF;
		write_regs(c, 1'b0);
		run_phase(300, 0, 0, 100);

		// random settings
		for (int k = 0; k < 2; k++) begin
			for (int i = 0; i < 4; i++) c.interval[i] = 16'($urandom_range(1, 65535));
			c.stable_needed = 8'($urandom_range(1, 16));
			c.hold_ms = 16'($urandom_range(0, 3000));
			c.heap_floor = 24'($urandom_range(0, 50000));
			write_regs(c, 1'b1);
			run_phase(150, 10, 5, c.hold_ms / 2 + 1);
		end

		// uneven intervals, no idling on either side
		c.interval[0] = 16'd50;
		c.interval[1] = 16'hFFFF;
		c.interval[2] = 16'd3;
		c.interval[3] = 16'd30000;
		c.stable_needed = 8'd2;
		c.hold_ms = 16'd100;
		c.heap_floor = 24'd4096;
		write_regs(c, 1'b0);
		quiet = 1'b1;
		run_phase(150, 10, 5, 60);
		quiet = 1'b0;

		// reset values again, time runs across the wrap
		c.interval[0] = RST_INTERVAL0;
		c.interval[1] = RST_INTERVAL1;
		c.interval[2] = RST_INTERVAL2;
		c.interval[3] = RST_INTERVAL3;
		c.stable_needed = RST_STABLE;
		c.hold_ms = RST_HOLD;
		c.heap_floor = RST_HEAP_FLOOR;
		write_regs(c, 1'b0);
		cur_now = 32'hFFFF_C000;
		run_phase(200, 3, 1, 1500);

		repeat (8) @(posedge clk);
		if (fail_count == 0)
			$display("adaptive_send_rate_controller test passed");
		else
			$display("adaptive_send_rate_controller test failed");
		$finish;
	end

endmodule
